>>> rtl/centered_moving_average_skip_missing_defines.svh
// Assertion macros for the centred moving average block.
// Used by the top level only; the bodies are empty under SYNTHESIS.
`ifndef CENTERED_MOVING_AVERAGE_SKIP_MISSING_DEFINES_SVH
`define CENTERED_MOVING_AVERAGE_SKIP_MISSING_DEFINES_SVH

`ifndef SYNTHESIS

`define CMASM_ASSERT_IMPL(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("cmasm: same-cycle check failed");

`define CMASM_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("cmasm: next-cycle check failed");

`else

`define CMASM_ASSERT_IMPL(label, cond, prop)

`define CMASM_ASSERT_NEXT(label, cond, prop)

`endif

`endif

>>> rtl/cmasm_pkg.sv
// Shared constants and types of the centred moving average block.
// No dependencies; used by every module of the block.
package cmasm_pkg;

    localparam int SAMPLE_BITS_DEF = 32;
    localparam int MAX_RADIUS      = 15;
    localparam int RADIUS_W        = 4;
    localparam int ADDR_W          = 5;
    localparam int RING_DEPTH      = 32;
    localparam int CNT_W           = 5;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd2;
    localparam logic [RADIUS_W-1:0] RADIUS_CAP   =
        RADIUS_W'((MAX_RADIUS < 15) ? MAX_RADIUS : 15);
    localparam logic [ADDR_W-1:0]   FILL_MAX     = 5'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_present;
        logic [ADDR_W-1:0] rd_addr;
        logic              clear;
    } mem_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> rtl/cmasm_window_mem.sv
// Ring store of the sample window: value memory plus present flags.
// Depends on cmasm_pkg for the address width and control struct.
module cmasm_window_mem #(
    parameter int SAMPLE_BITS = cmasm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmasm_pkg::mem_ctrl_t          ctrl,
    input  logic signed [SAMPLE_BITS-1:0] wr_value,
    output logic signed [SAMPLE_BITS-1:0] rd_value,
    output logic                          rd_present
);

    logic signed [SAMPLE_BITS-1:0]         value_mem [cmasm_pkg::RING_DEPTH];
    logic [cmasm_pkg::RING_DEPTH-1:0]      present_reg;
    logic signed [SAMPLE_BITS-1:0]         rd_value_reg;
    logic                                  rd_present_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            value_mem[ctrl.wr_addr] <= wr_value;
        end
        rd_value_reg <= value_mem[ctrl.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg    <= '0;
            rd_present_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                present_reg <= '0;
            end
            else if (ctrl.wr_en)
            begin
                present_reg[ctrl.wr_addr] <= ctrl.wr_present;
            end
            rd_present_reg <= present_reg[ctrl.rd_addr];
        end
    end

    assign rd_value   = rd_value_reg;
    assign rd_present = rd_present_reg;

endmodule

>>> rtl/cmasm_divider.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on cmasm_pkg for the status struct.
module cmasm_divider #(
    parameter int SUM_W = cmasm_pkg::SAMPLE_BITS_DEF + 5,
    parameter int DEN_W = cmasm_pkg::CNT_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [DEN_W-1:0]        divisor,
    output logic signed [SUM_W-1:0] quotient,
    output cmasm_pkg::div_status_t  status
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  mag_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;
    logic [DEN_W:0]    trial;
    logic              qbit;
    logic [DEN_W:0]    trial_sub;

    assign trial     = {rem_reg, mag_reg[SUM_W-1]};
    assign qbit      = (trial >= {1'b0, den_reg});
    assign trial_sub = trial - {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            mag_reg <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (step_reg != '0)
        begin
            mag_reg <= {mag_reg[SUM_W-2:0], qbit};
            rem_reg <= qbit ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= STEP_W'(SUM_W);
            end
            else if (step_reg != '0)
            begin
                step_reg <= step_reg - STEP_W'(1);
                done_reg <= (step_reg == STEP_W'(1));
            end
        end
    end

    assign quotient    = neg_reg ? (~mag_reg + SUM_W'(1)) : mag_reg;
    assign status.busy = (step_reg != '0);
    assign status.done = done_reg;

endmodule

>>> rtl/centered_moving_average_skip_missing.sv
// Centred moving average over a sample series, missing samples skipped.
// Depends on cmasm_pkg, cmasm_window_mem, cmasm_divider and the defines header.
//
// One sample is taken while the block is idle; it then produces zero or more
// results one after another and takes no sample until the last has been taken.
// Each result scans its window one ring entry per cycle (2r+1 entries at most)
// and, when two or more samples are present, runs the one-bit-per-cycle divider
// over the SAMPLE_BITS+5 bit sum. The default radius is 2, and a series end
// adds up to r more results.
`include "centered_moving_average_skip_missing_defines.svh"

module centered_moving_average_skip_missing #(
    parameter int SAMPLE_BITS = cmasm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [cmasm_pkg::RADIUS_W-1:0]        window_radius,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [SAMPLE_BITS-1:0]         sample_value,
    input  logic                                  sample_present,
    input  logic                                  series_end,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [SAMPLE_BITS-1:0]         average_value,
    output logic                                  average_present,
    output logic                                  final_result
);

    localparam int SUM_W = SAMPLE_BITS + 5;
    localparam int AW    = cmasm_pkg::ADDR_W;
    localparam int RW    = cmasm_pkg::RADIUS_W;
    localparam int CW    = cmasm_pkg::CNT_W;

    cmasm_pkg::state_t state_reg, state_next;

    logic [RW-1:0]                 radius_reg;
    logic [AW-1:0]                 slot_reg;
    logic [AW-1:0]                 fill_reg;
    logic [RW-1:0]                 r_reg;
    logic                          end_reg;
    logic                          norm_pend_reg;
    logic [RW-1:0]                 flush_cnt_reg;
    logic [RW-1:0]                 age_reg;
    logic                          last_reg;
    logic [AW-1:0]                 hi_reg;
    logic [AW-1:0]                 scan_reg;
    logic                          data_valid_reg;
    logic [AW-1:0]                 data_age_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic [CW-1:0]                 count_reg;
    logic signed [SAMPLE_BITS-1:0] centre_val_reg;
    logic                          centre_pres_reg;
    logic signed [SAMPLE_BITS-1:0] average_value_reg;
    logic                          average_present_reg;
    logic                          final_result_reg;

    logic                          in_accept;
    logic [RW-1:0]                 r_use;
    logic [AW-1:0]                 fill_inc;
    logic                          emit_any;
    logic [RW-1:0]                 emit_age;
    logic                          emit_last;
    logic [AW-1:0]                 age_plus_r;
    logic [AW-1:0]                 fill_top;
    logic [AW-1:0]                 emit_hi;
    logic                          div_start;
    logic                          series_clear;

    cmasm_pkg::mem_ctrl_t          mem_ctrl;
    cmasm_pkg::div_status_t        div_status;
    logic signed [SAMPLE_BITS-1:0] rd_value;
    logic                          rd_present;
    logic signed [SUM_W-1:0]       quotient;

    assign in_accept = in_valid && (state_reg == cmasm_pkg::ST_IDLE);
    assign r_use     = (radius_reg > cmasm_pkg::RADIUS_CAP) ? cmasm_pkg::RADIUS_CAP
                                                            : radius_reg;
    assign fill_inc  = (fill_reg == cmasm_pkg::FILL_MAX) ? fill_reg
                                                         : fill_reg + AW'(1);

    // pick the next result: the regular one first, then the flush results
    always_comb
    begin
        emit_any  = 1'b1;
        emit_age  = r_reg;
        emit_last = end_reg && (r_reg == '0);
        if (!norm_pend_reg)
        begin
            emit_age  = flush_cnt_reg - RW'(1);
            emit_last = (flush_cnt_reg == RW'(1));
            emit_any  = (flush_cnt_reg != '0);
        end
    end

    assign age_plus_r   = {1'b0, emit_age} + {1'b0, r_reg};
    assign fill_top     = fill_reg - AW'(1);
    assign emit_hi      = (age_plus_r > fill_top) ? fill_top : age_plus_r;
    assign series_clear = (state_reg == cmasm_pkg::ST_START) && !emit_any && end_reg;
    assign div_start    = (state_reg == cmasm_pkg::ST_DECIDE) && (count_reg > CW'(1));

    always_comb
    begin
        mem_ctrl.wr_en      = in_accept;
        mem_ctrl.wr_addr    = slot_reg;
        mem_ctrl.wr_present = sample_present;
        mem_ctrl.rd_addr    = slot_reg - AW'(1) - scan_reg;
        mem_ctrl.clear      = series_clear;
    end

    cmasm_window_mem #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mem_ctrl),
        .wr_value   (sample_value),
        .rd_value   (rd_value),
        .rd_present (rd_present)
    );

    cmasm_divider #(
        .SUM_W (SUM_W),
        .DEN_W (CW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .quotient (quotient),
        .status   (div_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cmasm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cmasm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cmasm_pkg::ST_START;
                end
            end
            cmasm_pkg::ST_START:
            begin
                state_next = emit_any ? cmasm_pkg::ST_SCAN : cmasm_pkg::ST_IDLE;
            end
            cmasm_pkg::ST_SCAN:
            begin
                if (scan_reg == hi_reg)
                begin
                    state_next = cmasm_pkg::ST_DRAIN;
                end
            end
            cmasm_pkg::ST_DRAIN:
            begin
                state_next = cmasm_pkg::ST_DECIDE;
            end
            cmasm_pkg::ST_DECIDE:
            begin
                state_next = div_start ? cmasm_pkg::ST_DIV : cmasm_pkg::ST_OUT;
            end
            cmasm_pkg::ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = cmasm_pkg::ST_OUT;
                end
            end
            cmasm_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = cmasm_pkg::ST_START;
                end
            end
            default:
            begin
                state_next = cmasm_pkg::ST_IDLE;
            end
        endcase
    end

    // series bookkeeping and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg     <= cmasm_pkg::RADIUS_RESET;
            slot_reg       <= '0;
            fill_reg       <= '0;
            norm_pend_reg  <= 1'b0;
            flush_cnt_reg  <= '0;
            end_reg        <= 1'b0;
            data_valid_reg <= 1'b0;
            sum_reg        <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                radius_reg <= window_radius;
            end
            data_valid_reg <= (state_reg == cmasm_pkg::ST_SCAN);
            if (in_accept)
            begin
                slot_reg      <= slot_reg + AW'(1);
                fill_reg      <= fill_inc;
                end_reg       <= series_end;
                norm_pend_reg <= (fill_inc > {1'b0, r_use});
                if (!series_end)
                begin
                    flush_cnt_reg <= '0;
                end
                else if (fill_inc < {1'b0, r_use})
                begin
                    flush_cnt_reg <= fill_inc[RW-1:0];
                end
                else
                begin
                    flush_cnt_reg <= r_use;
                end
            end
            if (state_reg == cmasm_pkg::ST_START)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                if (norm_pend_reg)
                begin
                    norm_pend_reg <= 1'b0;
                end
                else if (flush_cnt_reg != '0)
                begin
                    flush_cnt_reg <= flush_cnt_reg - RW'(1);
                end
                if (series_clear)
                begin
                    slot_reg <= '0;
                    fill_reg <= '0;
                end
            end
            else if (data_valid_reg && rd_present)
            begin
                sum_reg   <= sum_reg + {{(SUM_W-SAMPLE_BITS){rd_value[SAMPLE_BITS-1]}},
                                        rd_value};
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            r_reg <= r_use;
        end
        if (state_reg == cmasm_pkg::ST_START)
        begin
            age_reg  <= emit_age;
            last_reg <= emit_last;
            hi_reg   <= emit_hi;
            scan_reg <= '0;
        end
        else if (state_reg == cmasm_pkg::ST_SCAN)
        begin
            scan_reg <= scan_reg + AW'(1);
        end
        data_age_reg <= scan_reg;
        if (data_valid_reg && (data_age_reg == {1'b0, age_reg}))
        begin
            centre_val_reg  <= rd_present ? rd_value : '0;
            centre_pres_reg <= rd_present;
        end
        if ((state_reg == cmasm_pkg::ST_DECIDE) && !div_start)
        begin
            average_value_reg   <= centre_val_reg;
            average_present_reg <= centre_pres_reg;
            final_result_reg    <= last_reg;
        end
        else if ((state_reg == cmasm_pkg::ST_DIV) && div_status.done)
        begin
            average_value_reg   <= quotient[SAMPLE_BITS-1:0];
            average_present_reg <= 1'b1;
            final_result_reg    <= last_reg;
        end
    end

    assign in_stall        = (state_reg != cmasm_pkg::ST_IDLE);
    assign out_valid       = (state_reg == cmasm_pkg::ST_OUT);
    assign average_value   = average_value_reg;
    assign average_present = average_present_reg;
    assign final_result    = final_result_reg;

    `CMASM_ASSERT_IMPL(a_out_blocks_in, out_valid, in_stall)
    `CMASM_ASSERT_NEXT(a_div_to_out, (state_reg == cmasm_pkg::ST_DIV) && div_status.done, out_valid)
    `CMASM_ASSERT_IMPL(a_count_in_window, state_reg == cmasm_pkg::ST_DECIDE, count_reg <= hi_reg + AW'(1))

endmodule
